### hdl/magic_frame_deframer_crc16_core_defines.svh
// ----------------------------------------------------------------------------
// magic frame deframer assertion macros
// shared property templates for the deframer's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MAGIC_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH
`define MAGIC_FRAME_DEFRAMER_CRC16_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled while reset is low
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### hdl/mfdcrc16_pkg.sv
// ----------------------------------------------------------------------------
// mfdcrc16_pkg
// types and constants shared by the deframer and its crc unit
// ----------------------------------------------------------------------------
`default_nettype none

package mfdcrc16_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_MAGIC2  = 4'd2,
    PH_TYPE    = 4'd3,
    PH_CMD     = 4'd4,
    PH_LEN     = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRC_HI  = 4'd7,
    PH_CRC_LO  = 4'd8,
    PH_DONE    = 4'd9
  } phase_t;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [1:0]  status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_MAGIC = 2'd1;
  localparam status_t ST_CRC_ERR   = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam byte_t MAGIC_0 = 8'h4C;  // 'L'
  localparam byte_t MAGIC_1 = 8'h45;  // 'E'
  localparam byte_t MAGIC_2 = 8'h44;  // 'D'

  localparam crc_t CRC_POLY = 16'h1021;
  localparam crc_t CRC_INIT = 16'hFFFF;

endpackage

`default_nettype wire

### hdl/magic_frame_deframer_crc16_core.sv
// ----------------------------------------------------------------------------
// magic_frame_deframer_crc16_core
// deframer for 'LED' framed byte streams with crc-16/ccitt-false check
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per word, in_buffer_start marks the
//   first byte of a buffer; a start in mid-frame drops the old frame quietly
//   result channel: a payload word per payload byte as it arrives, and one
//   verdict word (out_last_of_frame set) at the end of each frame carrying
//   status (ok, bad magic, crc mismatch), with type, command and length
//   filled in only after a crc check (zero on bad magic)
//   a byte is loaded into the input register, and its result into the
//   result register when the byte moves on; throughput one byte per cycle
//   unless the result side stalls; the byte-wide crc update lies in between
//   a byte that yields no result never waits on the result side; a byte that
//   yields one waits in the input register while the result register is
//   full and stalled, and in_stall then holds back further bytes
//   reset clears the handshake and frame state; the block is idle and
//   ignores bytes until the first buffer start
// ----------------------------------------------------------------------------
`default_nettype none

module magic_frame_deframer_crc16_core (
  input  wire        clk,
  input  wire        rst_n,
  // byte input
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  input  wire        in_buffer_start,
  // results
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_packet_type,
  output logic [7:0] out_command_code,
  output logic [7:0] out_payload_length,
  output logic [1:0] out_status,
  output logic       out_last_of_frame
);

`include "magic_frame_deframer_crc16_core_defines.svh"

  // input register
  logic                  in_vld_r;
  mfdcrc16_pkg::byte_t   in_byte_r;
  logic                  in_start_r;

  // frame state
  mfdcrc16_pkg::phase_t  phase_r, phase_nxt;
  mfdcrc16_pkg::byte_t   frame_type_r, frame_type_nxt;
  mfdcrc16_pkg::byte_t   frame_cmd_r, frame_cmd_nxt;
  mfdcrc16_pkg::byte_t   decl_len_r, decl_len_nxt;
  mfdcrc16_pkg::byte_t   byte_cnt_r, byte_cnt_nxt;
  mfdcrc16_pkg::crc_t    crc_r, crc_nxt;
  mfdcrc16_pkg::byte_t   crc_hi_r, crc_hi_nxt;
  mfdcrc16_pkg::crc_t    crc_upd;

  // decoded result of the current byte
  logic                  has_res;
  logic                  res_verdict;
  logic                  res_fields;
  mfdcrc16_pkg::status_t res_status;
  logic                  fire;
  logic                  in_accept;

  // result register
  logic                  out_valid_r;
  logic                  out_kind_r, out_kind_nxt;
  mfdcrc16_pkg::byte_t   out_pbyte_r, out_pbyte_nxt;
  mfdcrc16_pkg::byte_t   out_pidx_r, out_pidx_nxt;
  mfdcrc16_pkg::byte_t   out_type_r, out_type_nxt;
  mfdcrc16_pkg::byte_t   out_cmd_r, out_cmd_nxt;
  mfdcrc16_pkg::byte_t   out_len_r, out_len_nxt;
  mfdcrc16_pkg::status_t out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  // crc of the running value with the byte held in the input register
  mfdcrc16_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_byte_r),
    .crc_out (crc_upd)
  );

  // the held byte moves on unless it has a result and the result slot is busy
  assign fire      = in_vld_r && (!has_res || !out_valid_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r  <= in_rx_byte;
      in_start_r <= in_buffer_start;
    end
  end

  // next frame state and result decode
  always_comb begin
    phase_nxt      = phase_r;
    frame_type_nxt = frame_type_r;
    frame_cmd_nxt  = frame_cmd_r;
    decl_len_nxt   = decl_len_r;
    byte_cnt_nxt   = byte_cnt_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    has_res        = 1'b0;
    res_verdict    = 1'b0;
    res_fields     = 1'b0;
    res_status     = mfdcrc16_pkg::ST_OK;
    if (in_start_r) begin
      // buffer start: fresh frame, this byte must be the first magic byte
      phase_nxt      = mfdcrc16_pkg::PH_MAGIC1;
      frame_type_nxt = '0;
      frame_cmd_nxt  = '0;
      decl_len_nxt   = '0;
      byte_cnt_nxt   = '0;
      crc_nxt        = mfdcrc16_pkg::CRC_INIT;
      crc_hi_nxt     = '0;
      if (in_byte_r != mfdcrc16_pkg::MAGIC_0) begin
        phase_nxt   = mfdcrc16_pkg::PH_DONE;
        has_res     = 1'b1;
        res_verdict = 1'b1;
        res_status  = mfdcrc16_pkg::ST_BAD_MAGIC;
      end
    end else begin
      case (phase_r)
        mfdcrc16_pkg::PH_MAGIC1: begin
          phase_nxt = mfdcrc16_pkg::PH_MAGIC2;
          if (in_byte_r != mfdcrc16_pkg::MAGIC_1) begin
            phase_nxt   = mfdcrc16_pkg::PH_DONE;
            has_res     = 1'b1;
            res_verdict = 1'b1;
            res_status  = mfdcrc16_pkg::ST_BAD_MAGIC;
          end
        end
        mfdcrc16_pkg::PH_MAGIC2: begin
          phase_nxt = mfdcrc16_pkg::PH_TYPE;
          if (in_byte_r != mfdcrc16_pkg::MAGIC_2) begin
            phase_nxt   = mfdcrc16_pkg::PH_DONE;
            has_res     = 1'b1;
            res_verdict = 1'b1;
            res_status  = mfdcrc16_pkg::ST_BAD_MAGIC;
          end
        end
        mfdcrc16_pkg::PH_TYPE: begin
          frame_type_nxt = in_byte_r;
          crc_nxt        = crc_upd;
          phase_nxt      = mfdcrc16_pkg::PH_CMD;
        end
        mfdcrc16_pkg::PH_CMD: begin
          frame_cmd_nxt = in_byte_r;
          crc_nxt       = crc_upd;
          phase_nxt     = mfdcrc16_pkg::PH_LEN;
        end
        mfdcrc16_pkg::PH_LEN: begin
          decl_len_nxt = in_byte_r;
          byte_cnt_nxt = '0;
          crc_nxt      = crc_upd;
          // zero length goes straight to the crc
          phase_nxt    = (in_byte_r == '0) ? mfdcrc16_pkg::PH_CRC_HI
                                           : mfdcrc16_pkg::PH_PAYLOAD;
        end
        mfdcrc16_pkg::PH_PAYLOAD: begin
          crc_nxt      = crc_upd;
          byte_cnt_nxt = byte_cnt_r + 8'd1;
          has_res      = 1'b1;
          if (byte_cnt_nxt == decl_len_r) begin
            phase_nxt = mfdcrc16_pkg::PH_CRC_HI;
          end
        end
        mfdcrc16_pkg::PH_CRC_HI: begin
          crc_hi_nxt = in_byte_r;
          phase_nxt  = mfdcrc16_pkg::PH_CRC_LO;
        end
        mfdcrc16_pkg::PH_CRC_LO: begin
          phase_nxt   = mfdcrc16_pkg::PH_DONE;
          has_res     = 1'b1;
          res_verdict = 1'b1;
          res_fields  = 1'b1;
          res_status  = ({crc_hi_r, in_byte_r} == crc_r) ? mfdcrc16_pkg::ST_OK
                                                         : mfdcrc16_pkg::ST_CRC_ERR;
        end
        default: begin
          // idle before any start, or trailing bytes after the crc
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // result word contents
  always_comb begin
    out_kind_nxt   = res_verdict ? mfdcrc16_pkg::KIND_VERDICT : mfdcrc16_pkg::KIND_PAYLOAD;
    out_pbyte_nxt  = res_verdict ? '0 : in_byte_r;
    out_pidx_nxt   = res_verdict ? '0 : byte_cnt_r;
    out_type_nxt   = res_fields ? frame_type_r : '0;
    out_cmd_nxt    = res_fields ? frame_cmd_r : '0;
    out_len_nxt    = res_fields ? decl_len_r : '0;
    out_status_nxt = res_verdict ? res_status : mfdcrc16_pkg::ST_OK;
    out_last_nxt   = res_verdict;
  end

  // frame state advances only when the held byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mfdcrc16_pkg::PH_IDLE;
      frame_type_r <= '0;
      frame_cmd_r  <= '0;
      decl_len_r   <= '0;
      byte_cnt_r   <= '0;
      crc_r        <= mfdcrc16_pkg::CRC_INIT;
      crc_hi_r     <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      frame_type_r <= frame_type_nxt;
      frame_cmd_r  <= frame_cmd_nxt;
      decl_len_r   <= decl_len_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
    end
  end

  // result register: filled on a firing byte with a result, emptied when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      out_kind_r   <= out_kind_nxt;
      out_pbyte_r  <= out_pbyte_nxt;
      out_pidx_r   <= out_pidx_nxt;
      out_type_r   <= out_type_nxt;
      out_cmd_r    <= out_cmd_nxt;
      out_len_r    <= out_len_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_payload_byte   = out_pbyte_r;
  assign out_payload_index  = out_pidx_r;
  assign out_packet_type    = out_type_r;
  assign out_command_code   = out_cmd_r;
  assign out_payload_length = out_len_r;
  assign out_status         = out_status_r;
  assign out_last_of_frame  = out_last_r;

  // a result is never written over one that is still waiting
  `MFD_ASSERT_SAME(a_no_overwrite, clk, rst_n, fire && has_res, !out_valid_r || !out_stall)
  // a firing byte with a result shows up in the result register next cycle
  `MFD_ASSERT_NEXT(a_result_lands, clk, rst_n, fire && has_res, out_valid_r)
  // while in the payload the count has not yet reached the declared length
  `MFD_ASSERT_SAME(a_payload_count, clk, rst_n, phase_r == mfdcrc16_pkg::PH_PAYLOAD,
                   byte_cnt_r != decl_len_r)

endmodule

`default_nettype wire

### hdl/mfdcrc16_crc_byte.sv
// ----------------------------------------------------------------------------
// mfdcrc16_crc_byte
// byte-wide crc-16 update, msb first, unrolled over the eight data bits
// ----------------------------------------------------------------------------
`default_nettype none

module mfdcrc16_crc_byte (
  input  wire mfdcrc16_pkg::crc_t  crc_in,
  input  wire mfdcrc16_pkg::byte_t data_in,
  output mfdcrc16_pkg::crc_t       crc_out
);

  always_comb begin
    mfdcrc16_pkg::crc_t c;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      if (data_in[i] != c[15]) begin
        c = {c[14:0], 1'b0} ^ mfdcrc16_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire
